// ===== design/mc3q_pkg.sv =====
// Package for the 3D Morton code quantizer: sizes, codes, beat types and bit functions.
`default_nettype none
package mc3q_pkg;

    localparam int AXIS_BITS = 10;
    localparam int CODE_BITS = 3 * AXIS_BITS;
    localparam int LEVEL_W   = 4;
    localparam int COORD_W   = 32;
    localparam int OCT_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = 2 * COORD_W;

    localparam logic [AXIS_BITS-1:0] CELL_MAX = {AXIS_BITS{1'b1}};

    typedef enum logic [1:0] {
        ACT_ENCODE  = 2'd0,
        ACT_DECODE  = 2'd1,
        ACT_EXTRACT = 2'd2,
        ACT_PLACE   = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_X   = 3'd0,
        REG_MIN_Y   = 3'd1,
        REG_MIN_Z   = 3'd2,
        REG_SCALE_X = 3'd3,
        REG_SCALE_Y = 3'd4,
        REG_SCALE_Z = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic [CODE_BITS-1:0]     code_in;
        logic [LEVEL_W-1:0]       level;
    } in_beat_t;

    typedef struct packed {
        logic [CODE_BITS-1:0] code_out;
        logic [AXIS_BITS-1:0] cell_x;
        logic [AXIS_BITS-1:0] cell_y;
        logic [AXIS_BITS-1:0] cell_z;
        logic [OCT_W-1:0]     octant;
    } out_beat_t;

    typedef struct packed {
        logic s1;
        logic s2;
    } stage_en_t;

    function automatic logic [CODE_BITS-1:0] spread(input logic [AXIS_BITS-1:0] c);
        logic [CODE_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < AXIS_BITS; i++)
        begin
            r[3*i] = c[i];
        end
        return r;
    endfunction

    function automatic logic [AXIS_BITS-1:0] compact(input logic [CODE_BITS-1:0] code,
                                                      input int axis);
        logic [AXIS_BITS-1:0] r;
        for (int i = 0; i < AXIS_BITS; i++)
        begin
            r[i] = code[3*i + axis];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/mc3q_axis.sv =====
// One axis of the quantizer: offset stage, multiply stage and saturation.
`default_nettype none
module mc3q_axis (
    input  wire                                clk,
    input  wire mc3q_pkg::stage_en_t           en,
    input  wire signed [mc3q_pkg::COORD_W-1:0] point,
    input  wire signed [mc3q_pkg::COORD_W-1:0] box_min,
    input  wire        [mc3q_pkg::COORD_W-1:0] scale,
    output logic       [mc3q_pkg::AXIS_BITS-1:0] cell_idx
);

    logic signed [mc3q_pkg::COORD_W:0]   diff;
    logic        [mc3q_pkg::COORD_W-1:0] offset_reg;
    logic        [mc3q_pkg::COORD_W-1:0] offset_next;
    logic        [mc3q_pkg::PROD_W-1:0]  prod_reg;
    logic        [mc3q_pkg::PROD_W-1:0]  prod_next;

    // offset of a point at or below the minimum is forced to zero
    always_comb
    begin
        diff = {point[mc3q_pkg::COORD_W-1], point} - {box_min[mc3q_pkg::COORD_W-1], box_min};
        offset_next = diff[mc3q_pkg::COORD_W] ? '0 : diff[mc3q_pkg::COORD_W-1:0];
        prod_next = mc3q_pkg::PROD_W'(offset_reg) * mc3q_pkg::PROD_W'(scale);
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            offset_reg <= offset_next;
        end
        if (en.s2)
        begin
            prod_reg <= prod_next;
        end
    end

    // integer part of the Q32.32 product, saturated
    always_comb
    begin
        if (|prod_reg[mc3q_pkg::PROD_W-1:mc3q_pkg::COORD_W+mc3q_pkg::AXIS_BITS])
        begin
            cell_idx = mc3q_pkg::CELL_MAX;
        end
        else
        begin
            cell_idx = prod_reg[mc3q_pkg::COORD_W +: mc3q_pkg::AXIS_BITS];
        end
    end

endmodule
`default_nettype wire

// ===== design/mc3q_fmt.sv =====
// Result formatting: interleave, decode, level extract and place per action.
`default_nettype none
module mc3q_fmt (
    input  wire [1:0]                          action,
    input  wire [mc3q_pkg::CODE_BITS-1:0]      code_in,
    input  wire [mc3q_pkg::LEVEL_W-1:0]        level,
    input  wire [mc3q_pkg::AXIS_BITS-1:0]      qx,
    input  wire [mc3q_pkg::AXIS_BITS-1:0]      qy,
    input  wire [mc3q_pkg::AXIS_BITS-1:0]      qz,
    output mc3q_pkg::out_beat_t                result
);

    logic [mc3q_pkg::OCT_W-1:0]     lvl_oct;
    logic [mc3q_pkg::CODE_BITS-1:0] lvl_code;

    always_comb
    begin
        lvl_oct  = '0;
        lvl_code = '0;
        for (int l = 0; l < mc3q_pkg::AXIS_BITS; l++)
        begin
            if (level == mc3q_pkg::LEVEL_W'(l))
            begin
                lvl_oct = code_in[mc3q_pkg::CODE_BITS-3*l-1 -: 3];
                lvl_code[mc3q_pkg::CODE_BITS-3*l-1 -: 3] = code_in[mc3q_pkg::OCT_W-1:0];
            end
        end
    end

    always_comb
    begin
        result = '0;
        case (mc3q_pkg::action_t'(action))
            mc3q_pkg::ACT_ENCODE:
            begin
                result.cell_x   = qx;
                result.cell_y   = qy;
                result.cell_z   = qz;
                result.code_out = mc3q_pkg::spread(qx)
                                | (mc3q_pkg::spread(qy) << 1)
                                | (mc3q_pkg::spread(qz) << 2);
            end
            mc3q_pkg::ACT_DECODE:
            begin
                result.cell_x = mc3q_pkg::compact(code_in, 0);
                result.cell_y = mc3q_pkg::compact(code_in, 1);
                result.cell_z = mc3q_pkg::compact(code_in, 2);
            end
            mc3q_pkg::ACT_EXTRACT:
            begin
                result.octant = lvl_oct;
            end
            mc3q_pkg::ACT_PLACE:
            begin
                result.code_out = lvl_code;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/morton_code_3d_quantizer_unit.sv =====
// Top level of the 3D Morton code quantizer: config registers, pipeline control, output stage.
//
// Input beats arrive on in_valid/in_stall/in_data, results leave on
// out_valid/out_stall/out_data, one result per input beat, in order.
// Actions: encode a Q16.16 point into a 30-bit Morton code and its cells,
// decode a code into cells, extract the octant of a level, place an
// octant at its level.
// There are 3 register stages: an accepted beat moves through the stage 1
// and stage 2 registers into the output register, where out_valid marks it.
// Stages: offset subtract, 32x32 multiply by the axis scale, then
// saturation, interleave and result select into the output register.
// Throughput is one beat per cycle while out_stall is low; the multiply stage sets the clock.
// A stall on out_stall holds the output register and backs up through
// the stages; in_stall rises only when all three stages are full.
// The user must write box minimum and scale through cfg_we/cfg_index/cfg_data
// only while the pipeline is empty; the block itself does not enforce it.
// Reset empties the pipeline, clears the minimums and sets each scale to 1.0.
`default_nettype none
module morton_code_3d_quantizer_unit (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_stall,
    input  wire mc3q_pkg::in_beat_t           in_data,
    output logic                              out_valid,
    input  wire                               out_stall,
    output mc3q_pkg::out_beat_t               out_data,
    input  wire                               cfg_we,
    input  wire [mc3q_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [mc3q_pkg::COORD_W-1:0]       cfg_data
);

    logic [mc3q_pkg::COORD_W-1:0] min_x_reg, min_y_reg, min_z_reg;
    logic [mc3q_pkg::COORD_W-1:0] scale_x_reg, scale_y_reg, scale_z_reg;

    logic v1_reg, v2_reg, v3_reg;
    logic ready1, ready2, ready3;
    mc3q_pkg::stage_en_t en;

    logic [1:0]                     act1_reg, act2_reg;
    logic [mc3q_pkg::CODE_BITS-1:0] code1_reg, code2_reg;
    logic [mc3q_pkg::LEVEL_W-1:0]   lvl1_reg, lvl2_reg;

    logic [mc3q_pkg::AXIS_BITS-1:0] qx, qy, qz;
    mc3q_pkg::out_beat_t            out_next;
    mc3q_pkg::out_beat_t            out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg   <= '0;
            min_y_reg   <= '0;
            min_z_reg   <= '0;
            scale_x_reg <= mc3q_pkg::COORD_W'(65536);
            scale_y_reg <= mc3q_pkg::COORD_W'(65536);
            scale_z_reg <= mc3q_pkg::COORD_W'(65536);
        end
        else if (cfg_we)
        begin
            case (mc3q_pkg::cfg_reg_t'(cfg_index))
                mc3q_pkg::REG_MIN_X:   min_x_reg   <= cfg_data;
                mc3q_pkg::REG_MIN_Y:   min_y_reg   <= cfg_data;
                mc3q_pkg::REG_MIN_Z:   min_z_reg   <= cfg_data;
                mc3q_pkg::REG_SCALE_X: scale_x_reg <= cfg_data;
                mc3q_pkg::REG_SCALE_Y: scale_y_reg <= cfg_data;
                mc3q_pkg::REG_SCALE_Z: scale_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        ready3   = !v3_reg || !out_stall;
        ready2   = !v2_reg || ready3;
        ready1   = !v1_reg || ready2;
        en.s1    = ready1;
        en.s2    = ready2;
        in_stall = !ready1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            act1_reg  <= in_data.action;
            code1_reg <= in_data.code_in;
            lvl1_reg  <= in_data.level;
        end
        if (ready2)
        begin
            act2_reg  <= act1_reg;
            code2_reg <= code1_reg;
            lvl2_reg  <= lvl1_reg;
        end
        if (ready3)
        begin
            out_reg <= out_next;
        end
    end

    mc3q_axis u_axis_x (
        .clk      (clk),
        .en       (en),
        .point    (in_data.point_x),
        .box_min  (min_x_reg),
        .scale    (scale_x_reg),
        .cell_idx (qx)
    );

    mc3q_axis u_axis_y (
        .clk      (clk),
        .en       (en),
        .point    (in_data.point_y),
        .box_min  (min_y_reg),
        .scale    (scale_y_reg),
        .cell_idx (qy)
    );

    mc3q_axis u_axis_z (
        .clk      (clk),
        .en       (en),
        .point    (in_data.point_z),
        .box_min  (min_z_reg),
        .scale    (scale_z_reg),
        .cell_idx (qz)
    );

    mc3q_fmt u_fmt (
        .action  (act2_reg),
        .code_in (code2_reg),
        .level   (lvl2_reg),
        .qx      (qx),
        .qy      (qy),
        .qz      (qz),
        .result  (out_next)
    );

    assign out_valid = v3_reg;
    assign out_data  = out_reg;

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg))
        else $error("input stalled with a bubble in the pipeline");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !ready2) |=> v1_reg)
        else $error("stage 1 beat lost while blocked");

    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(v3_reg) |-> $past(v2_reg))
        else $error("output valid without a beat in stage 2");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && ready3) |=> v3_reg)
        else $error("stage 2 beat not moved to output");

endmodule
`default_nettype wire

// ===== sim/morton_checker.sv =====
// Checker for the Morton code unit: tracks config, predicts each result beat and compares.
module morton_checker
    import mc3q_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    input  wire                    in_stall,
    input  in_beat_t               in_data,
    input  wire                    out_valid,
    input  wire                    out_stall,
    input  out_beat_t              out_data,
    input  wire                    cfg_we,
    input  wire [CFG_IDX_W-1:0]    cfg_index,
    input  wire [COORD_W-1:0]      cfg_data,
    output int                     mismatches,
    output int                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [COORD_W-1:0] box_min [3];
    logic [COORD_W-1:0]        box_scale [3];
    out_beat_t                 pending_results [$];
    out_beat_t                 want;
    int                        errs;

    function automatic logic [AXIS_BITS-1:0] quant_cell(input logic signed [COORD_W-1:0] p,
                                                        input logic signed [COORD_W-1:0] mn,
                                                        input logic [COORD_W-1:0] sc);
        longint      d;
        logic [63:0] du;
        logic [63:0] prod;
        logic [31:0] hi;
        d = longint'(p) - longint'(mn);
        if (d <= 0)
        begin
            return '0;
        end
        du   = d;
        prod = du * {32'd0, sc};
        hi   = prod[63:32];
        return (hi > 32'(CELL_MAX)) ? CELL_MAX : hi[AXIS_BITS-1:0];
    endfunction

    function automatic out_beat_t morton_predict(input in_beat_t b);
        out_beat_t            r;
        logic [AXIS_BITS-1:0] cx;
        logic [AXIS_BITS-1:0] cy;
        logic [AXIS_BITS-1:0] cz;
        int                   sh;
        r = '0;
        case (action_t'(b.action))
            ACT_ENCODE:
            begin
                cx = quant_cell(b.point_x, box_min[0], box_scale[0]);
                cy = quant_cell(b.point_y, box_min[1], box_scale[1]);
                cz = quant_cell(b.point_z, box_min[2], box_scale[2]);
                for (int i = 0; i < AXIS_BITS; i++)
                begin
                    r.code_out[3*i]   = cx[i];
                    r.code_out[3*i+1] = cy[i];
                    r.code_out[3*i+2] = cz[i];
                end
                r.cell_x = cx;
                r.cell_y = cy;
                r.cell_z = cz;
            end
            ACT_DECODE:
            begin
                for (int i = 0; i < AXIS_BITS; i++)
                begin
                    r.cell_x[i] = b.code_in[3*i];
                    r.cell_y[i] = b.code_in[3*i+1];
                    r.cell_z[i] = b.code_in[3*i+2];
                end
            end
            default:
            begin
                // level past the finest one yields zeros
                if (b.level < AXIS_BITS)
                begin
                    sh = CODE_BITS - 3 * (int'(b.level) + 1);
                    if (action_t'(b.action) == ACT_EXTRACT)
                    begin
                        r.octant = 3'(b.code_in >> sh);
                    end
                    else
                    begin
                        r.code_out = CODE_BITS'(b.code_in[2:0]) << sh;
                    end
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                box_min[i]   = '0;
                box_scale[i] = 32'h0001_0000;
            end
            pending_results.delete();
            errs = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_MIN_X:   box_min[0]   = cfg_data;
                    REG_MIN_Y:   box_min[1]   = cfg_data;
                    REG_MIN_Z:   box_min[2]   = cfg_data;
                    REG_SCALE_X: box_scale[0] = cfg_data;
                    REG_SCALE_Y: box_scale[1] = cfg_data;
                    REG_SCALE_Z: box_scale[2] = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                pending_results.push_back(morton_predict(in_data));
            end
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                    begin
                        $display("%0t unexpected result beat: code=%h cells=%0d/%0d/%0d oct=%0d",
                                 $realtime, out_data.code_out, out_data.cell_x,
                                 out_data.cell_y, out_data.cell_z, out_data.octant);
                    end
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_data.code_out !== want.code_out || out_data.cell_x !== want.cell_x ||
                        out_data.cell_y !== want.cell_y || out_data.cell_z !== want.cell_z ||
                        out_data.octant !== want.octant)
                    begin
                        errs++;
                        if (errs <= 10)
                        begin
                            $display("%0t mismatch: exp code=%h cells=%0d/%0d/%0d oct=%0d",
                                     $realtime, want.code_out, want.cell_x, want.cell_y,
                                     want.cell_z, want.octant);
                            $display("%0t           got code=%h cells=%0d/%0d/%0d oct=%0d",
                                     $realtime, out_data.code_out, out_data.cell_x,
                                     out_data.cell_y, out_data.cell_z, out_data.octant);
                        end
                    end
                end
            end
            mismatches  <= errs;
            outstanding <= pending_results.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the Morton code unit: clock, reset, stimulus, stall control and verdict.
module tb_top;
    import mc3q_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD = 300;
    localparam int DRAIN     = 10;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    in_beat_t               in_data;
    logic                   out_valid;
    logic                   out_stall;
    out_beat_t              out_data;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [COORD_W-1:0]     cfg_data;
    int                     mismatches;
    int                     outstanding;

    bit                     tx_jitter;
    bit                     rx_jitter;
    bit                     hold_req;
    logic signed [31:0]     cur_min [3];
    logic [31:0]            cur_ext [3];

    morton_code_3d_quantizer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    morton_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic in_beat_t mk(input action_t a, input logic [31:0] px, py, pz,
                                    input logic [29:0] code, input logic [3:0] lvl);
        in_beat_t b;
        b.action  = a;
        b.point_x = px;
        b.point_y = py;
        b.point_z = pz;
        b.code_in = code;
        b.level   = lvl;
        return b;
    endfunction

    function automatic in_beat_t rand_beat();
        in_beat_t    b;
        int unsigned sel;
        longint      off;
        b.action  = 2'($urandom);
        b.point_x = $urandom;
        b.point_y = $urandom;
        b.point_z = $urandom;
        b.code_in = 30'($urandom);
        b.level   = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9));
        sel = $urandom_range(0, 7);
        if (sel < 4)
        begin
            // mostly inside the box, with a margin on both sides
            b.action = ACT_ENCODE;
            off = longint'($urandom_range(0, cur_ext[0] + cur_ext[0] / 8)) - cur_ext[0] / 16;
            b.point_x = 32'(longint'(cur_min[0]) + off);
            off = longint'($urandom_range(0, cur_ext[1] + cur_ext[1] / 8)) - cur_ext[1] / 16;
            b.point_y = 32'(longint'(cur_min[1]) + off);
            off = longint'($urandom_range(0, cur_ext[2] + cur_ext[2] / 8)) - cur_ext[2] / 16;
            b.point_z = 32'(longint'(cur_min[2]) + off);
        end
        else if (sel == 4)
        begin
            b.action = ACT_DECODE;
        end
        else if (sel == 5)
        begin
            b.action = ACT_EXTRACT;
        end
        else if (sel == 6)
        begin
            b.action = ACT_PLACE;
        end
        return b;
    endfunction

    task automatic send_beat(input in_beat_t b);
        in_data  <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (tx_jitter && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic cfg_put(input cfg_reg_t r, input logic [31:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    task automatic program_box(input logic [31:0] mx, my, mz, sx, sy, sz);
        cfg_put(REG_MIN_X, mx);
        cfg_put(REG_MIN_Y, my);
        cfg_put(REG_MIN_Z, mz);
        cfg_put(REG_SCALE_X, sx);
        cfg_put(REG_SCALE_Y, sy);
        cfg_put(REG_SCALE_Z, sz);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_box(input int unsigned lo, input int unsigned hi);
        logic [31:0] sc [3];
        logic [63:0] q;
        for (int i = 0; i < 3; i++)
        begin
            cur_ext[i] = $urandom_range(lo, hi);
            cur_min[i] = $signed($urandom) >>> $urandom_range(1, 16);
            // scale = 1024 / extent in Q16.16
            q = (64'd1 << 42) / cur_ext[i];
            sc[i] = q[31:0];
        end
        wait_idle();
        program_box(cur_min[0], cur_min[1], cur_min[2], sc[0], sc[1], sc[2]);
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            send_beat(rand_beat());
        end
    endtask

    initial
    begin
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
                @(posedge clk);
            end
            else if (rx_jitter && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_MIN_X;
        cfg_data  = '0;
        tx_jitter = 1'b1;
        rx_jitter = 1'b1;
        hold_req  = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            cur_min[i] = '0;
            cur_ext[i] = 32'h0400_0000;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unit box: cells are the integer part of the point
        program_box(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_beat(mk(ACT_ENCODE, 32'h0, 32'h0, 32'h0, 30'h0, 4'd0));
        send_beat(mk(ACT_ENCODE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0005_8000, 30'h0, 4'd0));
        send_beat(mk(ACT_ENCODE, 32'h03FF_FFFF, 32'h0400_0000, 32'h0001_0000, 30'h0, 4'd0));
        send_beat(mk(ACT_ENCODE, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h02AA_0000,
                     30'h3FFF_FFFF, 4'hF));
        send_beat(mk(ACT_DECODE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     30'h3FFF_FFFF, 4'hF));
        send_beat(mk(ACT_DECODE, 32'h0, 32'h0, 32'h0, 30'h0, 4'd0));
        send_beat(mk(ACT_DECODE, 32'h0, 32'h0, 32'h0, 30'h0924_9249, 4'd0));
        send_beat(mk(ACT_DECODE, 32'h0, 32'h0, 32'h0, 30'h1249_2492, 4'd0));
        send_beat(mk(ACT_DECODE, 32'h0, 32'h0, 32'h0, 30'h2492_4924, 4'd0));
        send_beat(mk(ACT_EXTRACT, 32'h0, 32'h0, 32'h0, 30'h3FFF_FFFF, 4'd0));
        send_beat(mk(ACT_EXTRACT, 32'h0, 32'h0, 32'h0, 30'h2AAA_AAAA, 4'd9));
        send_beat(mk(ACT_EXTRACT, 32'h0, 32'h0, 32'h0, 30'h1555_5555, 4'd4));
        send_beat(mk(ACT_EXTRACT, 32'h0, 32'h0, 32'h0, 30'h3FFF_FFFF, 4'd10));
        send_beat(mk(ACT_EXTRACT, 32'h0, 32'h0, 32'h0, 30'h3FFF_FFFF, 4'd15));
        send_beat(mk(ACT_PLACE, 32'h0, 32'h0, 32'h0, 30'h3FFF_FFFF, 4'd0));
        send_beat(mk(ACT_PLACE, 32'h0, 32'h0, 32'h0, 30'h0000_0005, 4'd9));
        send_beat(mk(ACT_PLACE, 32'h0, 32'h0, 32'h0, 30'h0000_0007, 4'd10));
        send_beat(mk(ACT_PLACE, 32'h0, 32'h0, 32'h0, 30'h3FFF_FFFF, 4'd15));

        // extreme minimums, full and zero scale
        wait_idle();
        program_box(32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678,
                    32'hFFFF_FFFF, 32'h0001_0000, 32'h0);
        send_beat(mk(ACT_ENCODE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 30'h0, 4'd0));
        send_beat(mk(ACT_ENCODE, 32'h8000_0000, 32'h8000_0000, 32'h1234_5679, 30'h0, 4'd0));
        send_beat(mk(ACT_ENCODE, 32'h8000_0001, 32'h0, 32'h7FFF_0000, 30'h0, 4'd0));
        send_beat(mk(ACT_ENCODE, 32'h8000_0002, 32'h7FFF_FFFE, 32'h0, 30'h0, 4'd0));

        random_box(2048, 32'h4000_0000);
        run_random(120);

        // long receiver hold while the sender keeps offering
        random_box(2048, 32'h0100_0000);
        tx_jitter = 1'b0;
        hold_req  = 1'b1;
        run_random(60);
        tx_jitter = 1'b1;
        run_random(40);

        // small boxes; sender drains mid-phase
        random_box(1025, 65536);
        run_random(50);
        wait_idle();
        run_random(50);

        // arbitrary register contents
        wait_idle();
        cur_min[0] = $urandom;
        cur_min[1] = $urandom;
        cur_min[2] = $urandom;
        program_box(cur_min[0], cur_min[1], cur_min[2], $urandom, $urandom, $urandom);
        run_random(80);

        // back to back, no idling
        random_box(2048, 32'h4000_0000);
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
        run_random(100);

        wait_idle();
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
